/* design/tsr_pkg.sv */
// Shared constants and types for the tournament selection ranker.
package tsr_pkg;
    localparam int POP_MAX      = 128;
    localparam int IDX_W        = $clog2(POP_MAX);
    localparam int CNT_W        = IDX_W + 1;
    localparam int FIT_W        = 32;
    localparam int SWAP_W       = 7;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOUR = 1'd1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [FIT_W-1:0] fit_t;

    // one result beat
    typedef struct packed {
        idx_t best;
        idx_t second_best;
        idx_t worst;
        idx_t second_worst;
        logic last;
    } res_t;
endpackage

/* design/tsr_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/tournament_selection_ranker_unit.sv */
// Tournament selection ranker: loads fitness and swaps, then shuffles and ranks.
// Operation: the completing load beat starts a run that fills the rank table, visits
//   every shuffle position (swapping where its swap position is in range), then per
//   tournament runs selection-sort passes and reads out the four result indices.
// Throughput: loads every cycle; loads and config writes wait while a run is ranking.
// Reset: config returns to pop 128, tournament 2; load count cleared; stores undefined.
module tournament_selection_ranker_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        fitness,
    input  logic [6:0]                swap_position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [6:0]                best_index,
    output logic [6:0]                second_best_index,
    output logic [6:0]                worst_index,
    output logic [6:0]                second_worst_index,
    output logic                      last_event
);
    import tsr_pkg::*;

    typedef enum logic [15:0] {
        ST_LOAD  = 16'b0000000000000001,
        ST_FILL  = 16'b0000000000000010,
        ST_SH_A  = 16'b0000000000000100,
        ST_SH_B  = 16'b0000000000001000,
        ST_SH_C  = 16'b0000000000010000,
        ST_SH_D  = 16'b0000000000100000,
        ST_SH_E  = 16'b0000000001000000,
        ST_SO_J0 = 16'b0000000010000000,
        ST_SO_J1 = 16'b0000000100000000,
        ST_SO_J2 = 16'b0000001000000000,
        ST_SO_K1 = 16'b0000010000000000,
        ST_SO_K2 = 16'b0000100000000000,
        ST_SO_SW = 16'b0001000000000000,
        ST_SO_S2 = 16'b0010000000000000,
        ST_OU_RD = 16'b0100000000000000,
        ST_OUT   = 16'b1000000000000000
    } state_t;

    state_t state_reg;
    logic [7:0] pop_cfg_reg, tour_cfg_reg;
    cnt_t load_cnt_reg;
    cnt_t pop_reg;
    logic [7:0] ts_reg;
    cnt_t i_reg, j_reg, k_reg, m_reg, base_reg, end_reg;
    logic [2:0] ph_reg;
    idx_t p_reg, t1_reg, rj_reg, rm_reg, rk_reg;
    fit_t fm_reg;
    res_t res_reg;
    logic out_valid_reg;

    // memory ports
    logic fit_we;   idx_t fit_wa, fit_ra; fit_t fit_wd, fit_rd;
    logic swp_we;   idx_t swp_wa, swp_ra; logic [SWAP_W-1:0] swp_rd;
    logic rnk_we;   idx_t rnk_wa, rnk_ra; idx_t rnk_wd, rnk_rd;

    tsr_ram #(.WIDTH(FIT_W), .DEPTH(POP_MAX)) u_fit (.clk(clk), .we(fit_we),
        .waddr(fit_wa), .wdata(fit_wd), .raddr(fit_ra), .rdata(fit_rd));
    tsr_ram #(.WIDTH(SWAP_W), .DEPTH(POP_MAX)) u_swp (.clk(clk), .we(swp_we),
        .waddr(swp_wa), .wdata(swap_position), .raddr(swp_ra), .rdata(swp_rd));
    tsr_ram #(.WIDTH(IDX_W), .DEPTH(POP_MAX)) u_rnk (.clk(clk), .we(rnk_we),
        .waddr(rnk_wa), .wdata(rnk_wd), .raddr(rnk_ra), .rdata(rnk_rd));

    cnt_t eff_pop;
    logic [7:0] eff_ts;
    always_comb
    begin
        if (pop_cfg_reg < 8'd2) eff_pop = cnt_t'(2);
        else if (pop_cfg_reg > 8'(POP_MAX)) eff_pop = cnt_t'(POP_MAX);
        else eff_pop = cnt_t'(pop_cfg_reg);
        eff_ts = (tour_cfg_reg < 8'd2) ? 8'd2 : tour_cfg_reg;
    end

    assign cfg_ready = (state_reg == ST_LOAD);
    assign in_ready  = (state_reg == ST_LOAD);
    logic in_fire;
    assign in_fire = in_valid && in_ready;
    logic last_load;
    assign last_load = (load_cnt_reg + cnt_t'(1)) >= eff_pop;

    // tournament bounds, wide enough for any tournament size
    logic [9:0] base_ts, base_2ts;
    assign base_ts  = 10'(base_reg) + 10'(ts_reg);
    assign base_2ts = base_ts + 10'(ts_reg);
    logic ts_fits;
    assign ts_fits = 10'(ts_reg) <= 10'(pop_reg);
    logic sh_last;
    assign sh_last = (i_reg + cnt_t'(1)) == pop_reg;

    assign fit_we = in_fire;
    assign swp_we = in_fire;
    assign fit_wa = load_cnt_reg[IDX_W-1:0];
    assign swp_wa = load_cnt_reg[IDX_W-1:0];
    assign fit_wd = fit_t'(fitness);
    assign swp_ra = i_reg[IDX_W-1:0];
    assign fit_ra = rnk_rd;

    always_comb
    begin
        rnk_we = 1'b0;
        rnk_wa = i_reg[IDX_W-1:0];
        rnk_wd = i_reg[IDX_W-1:0];
        rnk_ra = i_reg[IDX_W-1:0];
        case (state_reg)
            ST_FILL:
            begin
                rnk_we = 1'b1;
            end
            ST_SH_C:
            begin
                rnk_ra = p_reg;
            end
            ST_SH_D:
            begin
                rnk_we = 1'b1;
                rnk_wd = rnk_rd;
            end
            ST_SH_E:
            begin
                rnk_we = 1'b1;
                rnk_wa = p_reg;
                rnk_wd = t1_reg;
            end
            ST_SO_J0:
            begin
                rnk_ra = j_reg[IDX_W-1:0];
            end
            ST_SO_J2:
            begin
                rnk_ra = k_reg[IDX_W-1:0];
            end
            ST_SO_K2:
            begin
                rnk_ra = idx_t'(k_reg + cnt_t'(1));
            end
            ST_SO_SW:
            begin
                rnk_we = (m_reg != j_reg);
                rnk_wa = j_reg[IDX_W-1:0];
                rnk_wd = rm_reg;
            end
            ST_SO_S2:
            begin
                rnk_we = 1'b1;
                rnk_wa = m_reg[IDX_W-1:0];
                rnk_wd = rj_reg;
            end
            ST_OU_RD:
            begin
                case (ph_reg)
                    3'd0:    rnk_ra = idx_t'(end_reg - cnt_t'(1));
                    3'd1:    rnk_ra = idx_t'(end_reg - cnt_t'(2));
                    3'd2:    rnk_ra = base_reg[IDX_W-1:0];
                    default: rnk_ra = idx_t'(base_reg + cnt_t'(1));
                endcase
            end
            default:
            begin
                rnk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pop_cfg_reg   <= 8'd128;
            tour_cfg_reg  <= 8'd2;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            pop_reg  <= '0; ts_reg <= '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; m_reg <= '0;
            base_reg <= '0; end_reg <= '0; ph_reg <= '0;
            p_reg <= '0; t1_reg <= '0; rj_reg <= '0; rm_reg <= '0; rk_reg <= '0;
            fm_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POP) pop_cfg_reg <= cfg_data;
                else if (cfg_index == REG_TOUR) tour_cfg_reg <= cfg_data;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (last_load)
                        begin
                            load_cnt_reg <= '0;
                            pop_reg <= eff_pop;
                            ts_reg  <= eff_ts;
                            i_reg   <= '0;
                            state_reg <= ST_FILL;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + cnt_t'(1);
                        end
                    end
                end
                ST_FILL:
                begin
                    if (sh_last)
                    begin
                        i_reg <= '0;
                        state_reg <= ST_SH_A;
                    end
                    else i_reg <= i_reg + cnt_t'(1);
                end
                ST_SH_A:
                begin
                    state_reg <= ST_SH_B;
                end
                ST_SH_B:
                begin
                    // swap partner is back; out of range skips this position
                    if (cnt_t'(swp_rd) < pop_reg)
                    begin
                        p_reg <= idx_t'(swp_rd);
                        state_reg <= ST_SH_C;
                    end
                    else if (!sh_last)
                    begin
                        i_reg <= i_reg + cnt_t'(1);
                        state_reg <= ST_SH_A;
                    end
                    else
                    begin
                        base_reg <= '0;
                        j_reg    <= '0;
                        end_reg  <= cnt_t'(ts_reg);
                        state_reg <= ts_fits ? ST_SO_J0 : ST_LOAD;
                    end
                end
                ST_SH_C:
                begin
                    t1_reg <= rnk_rd;
                    state_reg <= ST_SH_D;
                end
                ST_SH_D:
                begin
                    state_reg <= ST_SH_E;
                end
                ST_SH_E:
                begin
                    if (!sh_last)
                    begin
                        i_reg <= i_reg + cnt_t'(1);
                        state_reg <= ST_SH_A;
                    end
                    else
                    begin
                        base_reg <= '0;
                        j_reg    <= '0;
                        end_reg  <= cnt_t'(ts_reg);
                        state_reg <= ts_fits ? ST_SO_J0 : ST_LOAD;
                    end
                end
                ST_SO_J0:
                begin
                    state_reg <= ST_SO_J1;
                end
                ST_SO_J1:
                begin
                    rj_reg <= rnk_rd;
                    rm_reg <= rnk_rd;
                    m_reg  <= j_reg;
                    k_reg  <= j_reg + cnt_t'(1);
                    state_reg <= ST_SO_J2;
                end
                ST_SO_J2:
                begin
                    fm_reg <= fit_rd;
                    state_reg <= ST_SO_K1;
                end
                ST_SO_K1:
                begin
                    rk_reg <= rnk_rd;
                    state_reg <= ST_SO_K2;
                end
                ST_SO_K2:
                begin
                    // strict less-than keeps the earliest minimum
                    if (fit_rd < fm_reg)
                    begin
                        fm_reg <= fit_rd;
                        m_reg  <= k_reg;
                        rm_reg <= rk_reg;
                    end
                    if (k_reg + cnt_t'(1) == end_reg) state_reg <= ST_SO_SW;
                    else
                    begin
                        k_reg <= k_reg + cnt_t'(1);
                        state_reg <= ST_SO_K1;
                    end
                end
                ST_SO_SW, ST_SO_S2:
                begin
                    if (state_reg == ST_SO_SW && m_reg != j_reg) state_reg <= ST_SO_S2;
                    else if (j_reg + cnt_t'(2) < end_reg)
                    begin
                        j_reg <= j_reg + cnt_t'(1);
                        state_reg <= ST_SO_J0;
                    end
                    else
                    begin
                        ph_reg <= '0;
                        state_reg <= ST_OU_RD;
                    end
                end
                ST_OU_RD:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    case (ph_reg)
                        3'd1:    res_reg.best <= rnk_rd;
                        3'd2:    res_reg.second_best <= rnk_rd;
                        3'd3:    res_reg.worst <= rnk_rd;
                        3'd4:
                        begin
                            res_reg.second_worst <= rnk_rd;
                            res_reg.last  <= base_2ts > 10'(pop_reg);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        default: res_reg <= res_reg;
                    endcase
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        base_reg <= cnt_t'(base_ts);
                        j_reg    <= cnt_t'(base_ts);
                        end_reg  <= cnt_t'(base_2ts);
                        state_reg <= (base_2ts <= 10'(pop_reg)) ? ST_SO_J0 : ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign best_index         = 7'(res_reg.best);
    assign second_best_index  = 7'(res_reg.second_best);
    assign worst_index        = 7'(res_reg.worst);
    assign second_worst_index = 7'(res_reg.second_worst);
    assign last_event         = res_reg.last;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg));
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid));
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg < cnt_t'(POP_MAX));
endmodule
